// ===== rtl/best_fit_segment_allocator_defines.svh =====
// Assertion macros used by the allocator datapath.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define BFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BFSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg
// Types, codes and fixed widths of the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int SIZE_W     = 32;
  localparam int ALIGN_W    = 5;
  localparam int HANDLE_W   = 16;
  localparam int AGE_W      = 16;
  localparam int PAGE_IDX_W = 4;
  localparam int THR_W      = 16;
  localparam int GRAN_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int STAT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_GRAN = 1'b1;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd8;
  localparam logic [GRAN_W-1:0] GRAN_RESET = 5'd16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_PAGE   = 2'd1,
    STAT_NO_DESC   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    SM_ALLOC,
    SM_FREE,
    SM_MERGE
  } scan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_A_NEW,
    S_PF_RD,
    S_A_CALC,
    S_A_APPLY,
    S_A_W2,
    S_A_PFW,
    S_F_PFW,
    S_M_APPLY,
    S_F_WR,
    S_ERR_PAGE,
    S_ERR_DESC,
    S_ERR_HANDLE,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_SCAN,
    ACT_NEW_PAGE,
    ACT_PF_READ,
    ACT_CALC,
    ACT_SPLIT_USED,
    ACT_SPLIT_FREE,
    ACT_TAKE_WHOLE,
    ACT_ALLOC_PF,
    ACT_FREE_PF,
    ACT_MERGE,
    ACT_FINISH_FREE,
    ACT_ERR,
    ACT_OUT_LOAD
  } act_t;

  typedef struct packed {
    act_t  act;
    stat_t code;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic is_free;
    logic merging;
    logic pool_fail;
    logic e0_ok;
    logic split;
    logic spare_ok;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/bfsa_req_if.sv =====
// ----------------------------------------------------------------------------
// bfsa_req_if
// Request channel: one allocate or free command per beat.
// ----------------------------------------------------------------------------
interface bfsa_req_if import bfsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [SIZE_W-1:0]   req_size;
  logic [ALIGN_W-1:0]  align_log2;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, op, req_size, align_log2, handle, input ready);
  modport sink   (input valid, op, req_size, align_log2, handle, output ready);
endinterface

// ===== rtl/bfsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfsa_rsp_if
// Response channel: one result per beat.
// ----------------------------------------------------------------------------
interface bfsa_rsp_if import bfsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [PAGE_IDX_W-1:0] page_index;
  logic [SIZE_W-1:0]     block_offset;
  logic [SIZE_W-1:0]     aligned_offset;
  logic [SIZE_W-1:0]     block_bytes;
  logic [SIZE_W-1:0]     page_free_bytes;

  modport source (output valid, status, page_index, block_offset, aligned_offset,
                  block_bytes, page_free_bytes, input ready);
  modport sink   (input valid, status, page_index, block_offset, aligned_offset,
                  block_bytes, page_free_bytes, output ready);
endinterface

// ===== rtl/bfsa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bfsa_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface bfsa_cfg_if import bfsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bfsa_ram.sv =====
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsa_ctrl
// Sequencer for the allocator: scans, page grant, split and merge steps.
// ----------------------------------------------------------------------------
module bfsa_ctrl import bfsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.merging) begin
            state_next = sts.found ? S_M_APPLY : S_F_WR;
          end else if (sts.is_free) begin
            state_next = sts.found ? S_PF_RD : S_ERR_HANDLE;
          end else begin
            state_next = sts.found ? S_PF_RD : S_A_NEW;
          end
        end
      end
      S_A_NEW: begin
        if (sts.pool_fail)   state_next = S_ERR_PAGE;
        else if (!sts.e0_ok) state_next = S_ERR_DESC;
        else                 state_next = S_PF_RD;
      end
      S_PF_RD:   state_next = sts.is_free ? S_F_PFW : S_A_CALC;
      S_A_CALC:  state_next = S_A_APPLY;
      S_A_APPLY: begin
        if (!sts.split)        state_next = S_A_PFW;
        else if (sts.spare_ok) state_next = S_A_W2;
        else                   state_next = S_ERR_DESC;
      end
      S_A_W2:    state_next = S_A_PFW;
      S_A_PFW:   state_next = S_DONE;
      S_F_PFW:   state_next = S_SCAN;
      S_M_APPLY: state_next = S_SCAN;
      S_F_WR:    state_next = S_DONE;
      S_ERR_PAGE, S_ERR_DESC, S_ERR_HANDLE: state_next = S_DONE;
      S_DONE:    if (!sts.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.act  = ACT_NONE;
    cmd.code = STAT_OK;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.act = ACT_ACCEPT;
      end
      S_SCAN:  cmd.act = ACT_SCAN;
      S_A_NEW: if (!sts.pool_fail && sts.e0_ok) cmd.act = ACT_NEW_PAGE;
      S_PF_RD:  cmd.act = ACT_PF_READ;
      S_A_CALC: cmd.act = ACT_CALC;
      S_A_APPLY: begin
        if (!sts.split)        cmd.act = ACT_TAKE_WHOLE;
        else if (sts.spare_ok) cmd.act = ACT_SPLIT_USED;
      end
      S_A_W2:    cmd.act = ACT_SPLIT_FREE;
      S_A_PFW:   cmd.act = ACT_ALLOC_PF;
      S_F_PFW:   cmd.act = ACT_FREE_PF;
      S_M_APPLY: cmd.act = ACT_MERGE;
      S_F_WR:    cmd.act = ACT_FINISH_FREE;
      S_ERR_PAGE: begin
        cmd.act  = ACT_ERR;
        cmd.code = STAT_NO_PAGE;
      end
      S_ERR_DESC: begin
        cmd.act  = ACT_ERR;
        cmd.code = STAT_NO_DESC;
      end
      S_ERR_HANDLE: begin
        cmd.act  = ACT_ERR;
        cmd.code = STAT_NOT_FOUND;
      end
      S_DONE:  if (!sts.out_busy) cmd.act = ACT_OUT_LOAD;
      default: cmd.act = ACT_NONE;
    endcase
  end
endmodule

// ===== rtl/bfsa_dp.sv =====
// ----------------------------------------------------------------------------
// bfsa_dp
// Datapath: descriptor and page tables, scan compare, result register.
// ----------------------------------------------------------------------------
`include "best_fit_segment_allocator_defines.svh"

module bfsa_dp import bfsa_pkg::*; #(
  parameter int DESCRIPTORS = 64,
  parameter int PAGES       = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    in_op,
  input  logic [SIZE_W-1:0]       in_req_size,
  input  logic [ALIGN_W-1:0]      in_align_log2,
  input  logic [HANDLE_W-1:0]     in_handle,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STAT_W-1:0]       out_status,
  output logic [PAGE_IDX_W-1:0]   out_page_index,
  output logic [SIZE_W-1:0]       out_block_offset,
  output logic [SIZE_W-1:0]       out_aligned_offset,
  output logic [SIZE_W-1:0]       out_block_bytes,
  output logic [SIZE_W-1:0]       out_page_free_bytes
);
  localparam int IW = $clog2(DESCRIPTORS);
  localparam int CW = IW + 1;
  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int UW = $clog2(PAGES + 1);
  localparam int DW = 2 * SIZE_W + PW + HANDLE_W + AGE_W;

  // Configuration registers.
  logic [THR_W-1:0]  thr;
  logic [GRAN_W-1:0] gran;

  // Latched request.
  logic                op_free;
  logic [SIZE_W-1:0]   req_r;
  logic [ALIGN_W-1:0]  alog;
  logic [HANDLE_W-1:0] owner;

  // Scan state.
  logic [CW-1:0]  cnt;
  logic           pend;
  logic [IW-1:0]  pidx;
  scan_mode_t     mode;
  logic           found;
  logic [IW-1:0]  b_idx;
  logic [SIZE_W-1:0] b_start, b_len;
  logic [PW-1:0]  b_page;
  logic [HANDLE_W-1:0] b_owner;
  logic [AGE_W-1:0] b_ad;
  logic [IW-1:0]  e0, e1, sp;
  logic           e0_ok, e1_ok, sp_ok, newpg;

  // Working block.
  logic [IW-1:0]       c_idx;
  logic [SIZE_W-1:0]   c_start, c_len;
  logic [PW-1:0]       c_page;
  logic [HANDLE_W-1:0] c_owner;
  logic [SIZE_W-1:0]   al_r, take_out, pfree;
  logic [SIZE_W+1:0]   take_s;
  logic [SIZE_W+2:0]   ps1_r;

  logic [AGE_W-1:0] age;
  logic [UW-1:0]    pages_used;
  logic [DESCRIPTORS-1:0] free_f, used_f;

  stat_t               res_status;
  logic [PW-1:0]       res_page;
  logic [SIZE_W-1:0]   res_off, res_al, res_bytes, res_pf;

  // Memories.
  logic          d_we;
  logic [IW-1:0] d_waddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic          p_we;
  logic [PW-1:0] p_waddr;
  logic [SIZE_W-1:0] p_wdata, p_rdata;

  bfsa_ram #(.WIDTH(DW), .DEPTH(DESCRIPTORS)) u_desc_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(cnt[IW-1:0]), .rdata(d_rdata)
  );

  bfsa_ram #(.WIDTH(SIZE_W), .DEPTH(PAGES)) u_page_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(b_page), .rdata(p_rdata)
  );

  // Unpacked descriptor read data.
  logic [SIZE_W-1:0]   r_start, r_len;
  logic [PW-1:0]       r_page;
  logic [HANDLE_W-1:0] r_owner;
  logic [AGE_W-1:0]    r_age, r_ad;
  logic [SIZE_W:0]     amask, r_end, r_al, c_al, cur_end;
  logic [SIZE_W+2:0]   gmask, amask_w, ps;
  logic                fit, ahead, adj, hit, is_empty;
  logic [SIZE_W+1:0]   leftover;
  logic [SIZE_W-1:0]   pf_alloc, pf_free;

  assign r_start = d_rdata[DW-1 -: SIZE_W];
  assign r_len   = d_rdata[DW-SIZE_W-1 -: SIZE_W];
  assign r_page  = d_rdata[AGE_W+HANDLE_W +: PW];
  assign r_owner = d_rdata[AGE_W +: HANDLE_W];
  assign r_age   = d_rdata[AGE_W-1:0];

  // Age distance below the counter; a smaller distance is a newer stamp.
  assign r_ad  = age - r_age - AGE_W'(1);
  assign amask = (SIZE_W'(1) << alog) - (SIZE_W+1)'(1);
  assign r_end = {1'b0, r_start} + {1'b0, r_len};
  assign r_al  = ({1'b0, r_start} + amask) & ~amask;
  assign c_al  = ({1'b0, c_start} + amask) & ~amask;
  assign cur_end = {1'b0, c_start} + {1'b0, c_len};

  assign fit = free_f[pidx] && (r_al <= r_end) && ((r_end - r_al) >= {1'b0, req_r});
  assign ahead = !found || (r_len < b_len) || ((r_len == b_len) && (r_ad < b_ad));
  assign adj = free_f[pidx] && (r_page == c_page) &&
               ((r_end == {1'b0, c_start}) || ({1'b0, r_start} == cur_end));
  assign is_empty = !free_f[pidx] && !used_f[pidx];

  always_comb begin
    unique case (mode)
      SM_ALLOC: hit = fit && ahead;
      SM_FREE:  hit = used_f[pidx] && (r_owner == owner) && (!found || (r_ad < b_ad));
      SM_MERGE: hit = adj && ahead;
      default:  hit = 1'b0;
    endcase
  end

  // New page size: request rounded to the granule, then to the alignment.
  assign gmask   = ((SIZE_W+3)'(1) << gran) - (SIZE_W+3)'(1);
  assign amask_w = {2'b00, amask};
  assign ps      = (ps1_r + amask_w) & ~amask_w;
  assign leftover = {2'b00, c_len} - take_s;
  assign pf_alloc = pfree - take_out;
  assign pf_free  = p_rdata + c_len;

  always_comb begin
    sts.scan_done = (cnt == CW'(DESCRIPTORS)) && !pend;
    sts.found     = found;
    sts.is_free   = op_free;
    sts.merging   = (mode == SM_MERGE);
    sts.pool_fail = (pages_used >= UW'(PAGES)) || (ps[SIZE_W+2:SIZE_W] != '0);
    sts.e0_ok     = e0_ok;
    sts.split     = leftover > {{(SIZE_W+2-THR_W){1'b0}}, thr};
    sts.spare_ok  = sp_ok;
    sts.out_busy  = out_valid && !out_ready;
  end

  always_comb begin
    d_we    = 1'b0;
    d_waddr = c_idx;
    d_wdata = {c_start, c_len, c_page, c_owner, age};
    p_we    = 1'b0;
    p_waddr = c_page;
    p_wdata = pf_alloc;
    unique case (cmd.act)
      ACT_NEW_PAGE: begin
        d_we    = 1'b1;
        d_waddr = e0;
        d_wdata = {SIZE_W'(0), ps[SIZE_W-1:0], pages_used[PW-1:0], HANDLE_W'(0), age};
        p_we    = 1'b1;
        p_waddr = pages_used[PW-1:0];
        p_wdata = ps[SIZE_W-1:0];
      end
      ACT_SPLIT_USED: begin
        d_we    = 1'b1;
        d_waddr = sp;
        d_wdata = {c_start, take_s[SIZE_W-1:0], c_page, owner, age};
      end
      ACT_SPLIT_FREE: begin
        d_we    = 1'b1;
        d_wdata = {c_start + take_out, c_len - take_out, c_page, c_owner, age};
      end
      ACT_TAKE_WHOLE: begin
        d_we    = 1'b1;
        d_wdata = {c_start, c_len, c_page, owner, age};
      end
      ACT_ALLOC_PF: p_we = 1'b1;
      ACT_FREE_PF: begin
        p_we    = 1'b1;
        p_wdata = pf_free;
      end
      ACT_FINISH_FREE: d_we = 1'b1;
      default: d_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    ps1_r <= ({3'b000, req_r} + gmask) & ~gmask;
    if (rst) begin
      thr        <= THR_RESET;
      gran       <= GRAN_RESET;
      cnt        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      mode       <= SM_ALLOC;
      age        <= '0;
      pages_used <= '0;
      free_f     <= '0;
      used_f     <= '0;
      out_valid  <= 1'b0;
      e0_ok      <= 1'b0;
      e1_ok      <= 1'b0;
      sp_ok      <= 1'b0;
      newpg      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SPLIT_THR) thr  <= cfg_data[THR_W-1:0];
        if (cfg_index == REG_PAGE_GRAN) gran <= cfg_data[GRAN_W-1:0];
      end
      if (out_valid && out_ready && cmd.act != ACT_OUT_LOAD) out_valid <= 1'b0;

      unique case (cmd.act)
        ACT_ACCEPT: begin
          op_free <= in_op;
          req_r   <= in_req_size;
          alog    <= in_align_log2;
          owner   <= in_handle;
          mode    <= (in_op == OP_FREE) ? SM_FREE : SM_ALLOC;
          cnt     <= '0;
          pend    <= 1'b0;
          found   <= 1'b0;
          e0_ok   <= 1'b0;
          e1_ok   <= 1'b0;
          newpg   <= 1'b0;
        end
        ACT_SCAN: begin
          if (cnt < CW'(DESCRIPTORS)) begin
            pend <= 1'b1;
            pidx <= cnt[IW-1:0];
            cnt  <= cnt + CW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (hit) begin
              found   <= 1'b1;
              b_idx   <= pidx;
              b_start <= r_start;
              b_len   <= r_len;
              b_page  <= r_page;
              b_owner <= r_owner;
              b_ad    <= r_ad;
            end
            if (mode == SM_ALLOC && is_empty) begin
              if (!e0_ok) begin
                e0    <= pidx;
                e0_ok <= 1'b1;
              end else if (!e1_ok) begin
                e1    <= pidx;
                e1_ok <= 1'b1;
              end
            end
          end
        end
        ACT_NEW_PAGE: begin
          b_idx      <= e0;
          b_start    <= '0;
          b_len      <= ps[SIZE_W-1:0];
          b_page     <= pages_used[PW-1:0];
          b_owner    <= '0;
          free_f[e0] <= 1'b1;
          newpg      <= 1'b1;
          pages_used <= pages_used + UW'(1);
          age        <= age + AGE_W'(1);
        end
        ACT_PF_READ: begin
          c_idx   <= b_idx;
          c_start <= b_start;
          c_len   <= b_len;
          c_page  <= b_page;
          c_owner <= b_owner;
          sp      <= newpg ? e1 : e0;
          sp_ok   <= newpg ? e1_ok : e0_ok;
        end
        ACT_CALC: begin
          pfree  <= p_rdata;
          al_r   <= c_al[SIZE_W-1:0];
          take_s <= {1'b0, c_al} - {2'b00, c_start} + {2'b00, req_r};
        end
        ACT_SPLIT_USED: begin
          used_f[sp] <= 1'b1;
          take_out   <= take_s[SIZE_W-1:0];
          age        <= age + AGE_W'(1);
        end
        ACT_SPLIT_FREE: age <= age + AGE_W'(1);
        ACT_TAKE_WHOLE: begin
          free_f[c_idx] <= 1'b0;
          used_f[c_idx] <= 1'b1;
          take_out      <= c_len;
          age           <= age + AGE_W'(1);
        end
        ACT_ALLOC_PF: begin
          res_status <= STAT_OK;
          res_page   <= c_page;
          res_off    <= c_start;
          res_al     <= al_r;
          res_bytes  <= take_out;
          res_pf     <= pf_alloc;
        end
        ACT_FREE_PF: begin
          res_status    <= STAT_OK;
          res_page      <= c_page;
          res_off       <= c_start;
          res_al        <= c_start;
          res_bytes     <= c_len;
          res_pf        <= pf_free;
          used_f[c_idx] <= 1'b0;
          mode          <= SM_MERGE;
          cnt           <= '0;
          pend          <= 1'b0;
          found         <= 1'b0;
        end
        ACT_MERGE: begin
          // A partner that ends where the block starts moves the start down.
          if ({1'b0, b_start} + {1'b0, b_len} == {1'b0, c_start}) c_start <= b_start;
          c_len         <= c_len + b_len;
          free_f[b_idx] <= 1'b0;
          cnt           <= '0;
          pend          <= 1'b0;
          found         <= 1'b0;
        end
        ACT_FINISH_FREE: begin
          free_f[c_idx] <= 1'b1;
          age           <= age + AGE_W'(1);
        end
        ACT_ERR: begin
          res_status <= cmd.code;
          res_page   <= '0;
          res_off    <= '0;
          res_al     <= '0;
          res_bytes  <= '0;
          res_pf     <= '0;
        end
        ACT_OUT_LOAD: begin
          out_valid           <= 1'b1;
          out_status          <= res_status;
          out_page_index      <= PAGE_IDX_W'(res_page);
          out_block_offset    <= res_off;
          out_aligned_offset  <= res_al;
          out_block_bytes     <= res_bytes;
          out_page_free_bytes <= res_pf;
        end
        default: begin
        end
      endcase
    end
  end

  `BFSA_ASSERT(a_pages_bound, pages_used <= UW'(PAGES), "page count beyond pool")
  `BFSA_ASSERT(a_kind_excl, (free_f & used_f) == '0, "descriptor both free and used")
  `BFSA_ASSERT(a_scan_bound, cnt <= CW'(DESCRIPTORS), "scan index past table")
  `BFSA_ASSERT(a_out_load, cmd.act == ACT_OUT_LOAD |=> out_valid, "result not presented")
endmodule

// ===== rtl/best_fit_segment_allocator.sv =====
// Allocate: accept, a table scan, then page read, offset calculation, apply and page-free
// write up to the result register; a new page and a split each add a state.
// Free: accept, an owner scan, a page read and page-free write, then per merge partner
// a scan and an apply step, and a final scan plus the descriptor write and output load.
// One operation in flight; the next beat is taken once the result is registered.
// Synchronous reset clears descriptor kinds, page count, age counter, scan state and output valid.
// ----------------------------------------------------------------------------
// best_fit_segment_allocator
// Best-fit segment allocator over a bounded pool of pages with coalescing.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator import bfsa_pkg::*; #(
  parameter int DESCRIPTORS = 64,
  parameter int PAGES       = 16
) (
  input logic         clk,
  input logic         rst,
  bfsa_req_if.sink    req,
  bfsa_rsp_if.source  rsp,
  bfsa_cfg_if.sink    cfg
);
  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  bfsa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .sts(sts), .cmd(cmd)
  );

  bfsa_dp #(.DESCRIPTORS(DESCRIPTORS), .PAGES(PAGES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(req.op), .in_req_size(req.req_size),
    .in_align_log2(req.align_log2), .in_handle(req.handle),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_status(rsp.status), .out_page_index(rsp.page_index),
    .out_block_offset(rsp.block_offset), .out_aligned_offset(rsp.aligned_offset),
    .out_block_bytes(rsp.block_bytes), .out_page_free_bytes(rsp.page_free_bytes)
  );
endmodule

// ===== tb/best_fit_segment_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_tb
// Self-checking testbench for the best-fit segment allocator. A behavioral
// model of the descriptor table and page pool predicts every response. The
// stimulus is directed cases, then register extremes, descriptor and page pool
// exhaustion, back pressure, and long random phases. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_tb;
  import bfsa_pkg::*;

  localparam int NUM_DESC    = 64;
  localparam int NUM_PAGES   = 16;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 3000;

  typedef enum logic [1:0] {SEG_EMPTY, SEG_FREE, SEG_USED} seg_kind_t;

  typedef struct {
    stat_t             status;
    logic [3:0]        page;
    logic [SIZE_W-1:0] boff;
    logic [SIZE_W-1:0] aoff;
    logic [SIZE_W-1:0] bytes;
    logic [SIZE_W-1:0] pfree;
  } outcome_t;

  logic clk;
  logic rst;

  bfsa_req_if req ();
  bfsa_rsp_if rsp ();
  bfsa_cfg_if cfg ();

  best_fit_segment_allocator dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  // Model of the allocator state.
  seg_kind_t         seg_kind [NUM_DESC];
  logic [31:0]       seg_start [NUM_DESC];
  logic [31:0]       seg_len [NUM_DESC];
  logic [3:0]        seg_page [NUM_DESC];
  logic [15:0]       seg_owner [NUM_DESC];
  logic [15:0]       seg_age [NUM_DESC];
  logic [31:0]       pool_free [NUM_PAGES];
  int                pages_taken;
  logic [15:0]       stamp_counter;
  logic [THR_W-1:0]  split_thr;
  logic [GRAN_W-1:0] gran_log2;

  outcome_t    pending_outcomes[$];
  logic [15:0] live_handles[$];
  int          mismatches;
  int          cycle_count;
  bit          hold_request;
  int          hold_left;
  int          stall_phase;
  int          burst_left;
  bit          req_held;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint unsigned round_to(longint unsigned v, longint unsigned a);
    return (v + a - 1) & ~(a - 1);
  endfunction

  function automatic logic [15:0] next_stamp();
    logic [15:0] s;
    s = stamp_counter;
    stamp_counter = stamp_counter + 16'd1;
    return s;
  endfunction

  function automatic logic [15:0] age_gap(int i);
    return stamp_counter - seg_age[i] - 16'd1;
  endfunction

  // Free-list order: smaller first, then newer, then lower index.
  function automatic bit ahead_of(int i, int j);
    if (seg_len[i] != seg_len[j]) return seg_len[i] < seg_len[j];
    if (age_gap(i) != age_gap(j)) return age_gap(i) < age_gap(j);
    return i < j;
  endfunction

  function automatic int first_empty();
    for (int i = 0; i < NUM_DESC; i++)
      if (seg_kind[i] == SEG_EMPTY) return i;
    return -1;
  endfunction

  function automatic outcome_t blank_outcome(stat_t s);
    outcome_t o;
    o.status = s;
    o.page = '0;
    o.boff = '0;
    o.aoff = '0;
    o.bytes = '0;
    o.pfree = '0;
    return o;
  endfunction

  function automatic outcome_t predict_alloc(logic [31:0] size, logic [4:0] alog,
                                             logic [15:0] owner);
    longint unsigned align, off, al, pad, take, leftover, fin, ps, rq;
    int best, n;
    logic [3:0] pg;
    outcome_t o;
    rq = size;
    align = 64'd1 << alog;
    best = -1;
    for (int i = 0; i < NUM_DESC; i++) begin
      if (seg_kind[i] != SEG_FREE) continue;
      off = seg_start[i];
      fin = off + seg_len[i];
      al = round_to(off, align);
      if (al > fin || fin - al < rq) continue;
      if (best < 0 || ahead_of(i, best)) best = i;
    end
    if (best < 0) begin
      ps = round_to(round_to(rq, 64'd1 << gran_log2), align);
      if (pages_taken >= NUM_PAGES || ps > 64'hFFFF_FFFF) return blank_outcome(STAT_NO_PAGE);
      n = first_empty();
      if (n < 0) return blank_outcome(STAT_NO_DESC);
      pg = pages_taken[3:0];
      pages_taken++;
      pool_free[pg] = ps[31:0];
      seg_kind[n] = SEG_FREE;
      seg_start[n] = '0;
      seg_len[n] = ps[31:0];
      seg_page[n] = pg;
      seg_owner[n] = '0;
      seg_age[n] = next_stamp();
      best = n;
    end
    off = seg_start[best];
    al = round_to(off, align);
    pad = al - off;
    leftover = longint'(seg_len[best]) - pad - rq;
    pg = seg_page[best];
    if (leftover > split_thr) begin
      n = first_empty();
      if (n < 0) return blank_outcome(STAT_NO_DESC);
      take = pad + rq;
      seg_kind[n] = SEG_USED;
      seg_start[n] = off[31:0];
      seg_len[n] = take[31:0];
      seg_page[n] = pg;
      seg_owner[n] = owner;
      seg_age[n] = next_stamp();
      seg_start[best] = off[31:0] + take[31:0];
      seg_len[best] = seg_len[best] - take[31:0];
      seg_age[best] = next_stamp();
    end else begin
      take = seg_len[best];
      seg_kind[best] = SEG_USED;
      seg_owner[best] = owner;
      seg_age[best] = next_stamp();
    end
    pool_free[pg] = pool_free[pg] - take[31:0];
    o.status = STAT_OK;
    o.page = pg;
    o.boff = off[31:0];
    o.aoff = al[31:0];
    o.bytes = take[31:0];
    o.pfree = pool_free[pg];
    return o;
  endfunction

  function automatic outcome_t predict_free(logic [15:0] owner);
    int f, m;
    logic [3:0] pg;
    longint unsigned s, fs;
    outcome_t o;
    f = -1;
    for (int i = 0; i < NUM_DESC; i++) begin
      if (seg_kind[i] != SEG_USED || seg_owner[i] != owner) continue;
      if (f < 0 || age_gap(i) < age_gap(f)) f = i;
    end
    if (f < 0) return blank_outcome(STAT_NOT_FOUND);
    pg = seg_page[f];
    pool_free[pg] = pool_free[pg] + seg_len[f];
    o.status = STAT_OK;
    o.page = pg;
    o.boff = seg_start[f];
    o.aoff = seg_start[f];
    o.bytes = seg_len[f];
    o.pfree = pool_free[pg];
    seg_kind[f] = SEG_EMPTY;
    // Coalesce with neighbors until none is left in the same page.
    forever begin
      m = -1;
      for (int i = 0; i < NUM_DESC; i++) begin
        if (seg_kind[i] != SEG_FREE || seg_page[i] != pg) continue;
        s = seg_start[i];
        fs = seg_start[f];
        if (s + seg_len[i] != fs && s != fs + seg_len[f]) continue;
        if (m < 0 || ahead_of(i, m)) m = i;
      end
      if (m < 0) break;
      if (longint'(seg_start[m]) + seg_len[m] == longint'(seg_start[f]))
        seg_start[f] = seg_start[m];
      seg_len[f] = seg_len[f] + seg_len[m];
      seg_kind[m] = SEG_EMPTY;
    end
    seg_kind[f] = SEG_FREE;
    seg_age[f] = next_stamp();
    return o;
  endfunction

  // Response side: stall pattern, long hold-off, and the scoreboard check.
  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected response beat: status %0d", rsp.status);
        end else begin
          e = pending_outcomes.pop_front();
          if (rsp.status !== e.status || rsp.page_index !== e.page ||
              rsp.block_offset !== e.boff || rsp.aligned_offset !== e.aoff ||
              rsp.block_bytes !== e.bytes || rsp.page_free_bytes !== e.pfree) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: exp st=%0d pg=%0d off=%h al=%h len=%h free=%h, got st=%0d pg=%0d off=%h al=%h len=%h free=%h",
                       e.status, e.page, e.boff, e.aoff, e.bytes, e.pfree,
                       rsp.status, rsp.page_index, rsp.block_offset, rsp.aligned_offset,
                       rsp.block_bytes, rsp.page_free_bytes);
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_phase % 160 >= 96) begin
        rsp.ready <= ($urandom_range(0, 2) != 0);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic issue_request(logic op, logic [31:0] size, logic [4:0] alog, logic [15:0] h);
    outcome_t o;
    req.valid <= 1'b1;
    req.op <= op;
    req.req_size <= size;
    req.align_log2 <= alog;
    req.handle <= h;
    req_held = 1'b1;
    do @(posedge clk); while (!req.ready);
    o = (op == OP_FREE) ? predict_free(h) : predict_alloc(size, alog, h);
    pending_outcomes.push_back(o);
    if (o.status == STAT_OK) begin
      if (op == OP_ALLOC) begin
        live_handles.push_back(h);
      end else begin
        foreach (live_handles[k])
          if (live_handles[k] == h) begin
            live_handles.delete(k);
            break;
          end
      end
    end
    // Bursts of random length separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        req.valid <= 1'b0;
        req_held = 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    if (req_held) begin
      req.valid <= 1'b0;
      req_held = 1'b0;
    end
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_SPLIT_THR) split_thr = value;
    else gran_log2 = value[GRAN_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_basic_ops();
    issue_request(OP_ALLOC, 32'd100, 5'd0, 16'd1);
    issue_request(OP_ALLOC, 32'd0, 5'd0, 16'd2);
    issue_request(OP_ALLOC, 32'd64, 5'd24, 16'd3);
    issue_request(OP_ALLOC, 32'hFFFF_FFFF, 5'd0, 16'd4);
    issue_request(OP_FREE, 32'hFFFF_FFFF, 5'd31, 16'd1);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd1);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd2);
    issue_request(OP_ALLOC, 32'd200, 5'd4, 16'd5);
    issue_request(OP_ALLOC, 32'd30, 5'd13, 16'd6);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd3);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'hFFFF);
    issue_request(OP_ALLOC, 32'd60000, 5'd12, 16'hFFFF);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd5);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd6);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_SPLIT_THR, 16'd0);
    issue_request(OP_ALLOC, 32'd10, 5'd0, 16'd7);
    issue_request(OP_ALLOC, 32'd10, 5'd3, 16'd7);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd7);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd7);
    write_reg(REG_SPLIT_THR, 16'hFFFF);
    issue_request(OP_ALLOC, 32'd5, 5'd0, 16'd8);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd8);
    write_reg(REG_PAGE_GRAN, 16'd12);
    issue_request(OP_ALLOC, 32'd5000, 5'd3, 16'd9);
    write_reg(REG_PAGE_GRAN, 16'd24);
    issue_request(OP_ALLOC, 32'd1, 5'd0, 16'd10);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd9);
    issue_request(OP_FREE, 32'd0, 5'd0, 16'd10);
    write_reg(REG_SPLIT_THR, THR_RESET);
    write_reg(REG_PAGE_GRAN, {11'd0, GRAN_RESET});
  endtask

  // Split every request off so the descriptor table runs dry.
  task automatic test_descriptor_exhaustion();
    int k;
    write_reg(REG_SPLIT_THR, 16'd0);
    k = 0;
    while (k < 80 && !(pending_outcomes.size() != 0 &&
                       pending_outcomes[$].status == STAT_NO_DESC)) begin
      issue_request(OP_ALLOC, 32'd1, 5'd0, 16'h0100 + k[15:0]);
      k++;
    end
    issue_request(OP_ALLOC, 32'hFFFF_0000, 5'd0, 16'h0200);
    for (int j = 0; j < k; j++) issue_request(OP_FREE, 32'd0, 5'd0, 16'h0100 + j[15:0]);
    write_reg(REG_SPLIT_THR, THR_RESET);
  endtask

  task automatic test_pool_exhaustion();
    for (int k = 0; k < 20; k++) issue_request(OP_ALLOC, 32'h1000_0000, 5'd0, 16'h0300);
    for (int k = 0; k < 20; k++) issue_request(OP_FREE, 32'd0, 5'd0, 16'h0300);
  endtask

  // The response side holds off while requests keep coming.
  task automatic test_backpressure();
    wait_drained();
    hold_request = 1'b1;
    burst_left = 40;
    for (int k = 0; k < 30; k++) issue_request(OP_ALLOC, $urandom_range(0, 300), 5'd2, 16'h0400);
    for (int k = 0; k < 30; k++) issue_request(OP_FREE, 32'd0, 5'd0, 16'h0400);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [31:0] size;
    logic [4:0]  alog;
    logic [15:0] h;
    int r;
    int pick;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (pick < 70) size = $urandom_range(0, 512);
      else if (pick < 90) size = $urandom_range(0, 70000);
      else if (pick < 97) size = $urandom_range(0, 1 << 20);
      else size = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 80) alog = $urandom_range(0, 6);
      else if (pick < 95) alog = $urandom_range(7, 24);
      else alog = $urandom_range(25, 31);
      h = ($urandom_range(0, 6) != 0) ? 16'($urandom_range(0, 31)) : 16'($urandom);
      if (r < 55) begin
        issue_request(OP_ALLOC, size, alog, h);
      end else if (r < 92 && live_handles.size() != 0) begin
        issue_request(OP_FREE, size, alog,
                      live_handles[$urandom_range(0, live_handles.size() - 1)]);
      end else begin
        issue_request(OP_FREE, size, alog, h);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = OP_ALLOC;
    req.req_size = '0;
    req.align_log2 = '0;
    req.handle = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_SPLIT_THR;
    cfg.data = '0;
    foreach (seg_kind[i]) seg_kind[i] = SEG_EMPTY;
    pages_taken = 0;
    stamp_counter = '0;
    split_thr = THR_RESET;
    gran_log2 = GRAN_RESET;
    mismatches = 0;
    cycle_count = 0;
    hold_request = 1'b0;
    hold_left = 0;
    stall_phase = 0;
    burst_left = 0;
    req_held = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_register_extremes();
    test_descriptor_exhaustion();
    test_backpressure();
    test_random(400);
    write_reg(REG_SPLIT_THR, 16'd0);
    write_reg(REG_PAGE_GRAN, 16'd13);
    test_random(300);
    write_reg(REG_SPLIT_THR, 16'd512);
    write_reg(REG_PAGE_GRAN, 16'd20);
    test_random(300);
    test_pool_exhaustion();
    write_reg(REG_SPLIT_THR, 16'hFFFF);
    write_reg(REG_PAGE_GRAN, 16'd24);
    test_random(250);
    write_reg(REG_SPLIT_THR, THR_RESET);
    write_reg(REG_PAGE_GRAN, 16'd12);
    test_random(250);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bfsa_pkg.sv
rtl/bfsa_req_if.sv
rtl/bfsa_rsp_if.sv
rtl/bfsa_cfg_if.sv
rtl/bfsa_ram.sv
rtl/bfsa_ctrl.sv
rtl/bfsa_dp.sv
rtl/best_fit_segment_allocator.sv
tb/best_fit_segment_allocator_tb.sv
